// ===== hw/rtl/hslt_pkg.sv =====
// ----------------------------------------------------------------------------
// hslt_pkg
// shared types and constants of the heard station recency table
// ----------------------------------------------------------------------------
package hslt_pkg;

  localparam int CNT_W  = 7;
  localparam int PORT_W = 4;
  localparam int TIME_W = 32;
  localparam int RANK_W = 6;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_RANK
  } rd_sel_e;

  typedef struct packed {
    logic    idle;
    logic    load_item;
    logic    scan_init;
    logic    scan_step;
    logic    shift_setup;
    logic    shift_wr;
    logic    insert;
    logic    finish;
    logic    rd_en;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic op_read;
    logic scan_more;
    logic match;
    logic found;
    logic idx_zero;
    logic cap_zero;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/heard_station_lru_table.sv =====
// ----------------------------------------------------------------------------
// heard_station_lru_table
// recency ordered table of heard stations with move to front on update
// ----------------------------------------------------------------------------
// read item: load, table read at the rank, then result register
// heard item: scan to a match, shift entries ahead of the slot back one place,
// insert at the front, register the result; with capacity zero no shift or insert
// throughput: one item at a time, limited by the single table ram port pair
// reset: table empty, capacity 10, no result pending; no clearing pass
module heard_station_lru_table #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ID_BITS       = 56
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [hslt_pkg::CNT_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [ID_BITS-1:0]          station_id_i,
  input  logic [hslt_pkg::PORT_W-1:0] port_number_i,
  input  logic                        is_transmit_i,
  input  logic [hslt_pkg::TIME_W-1:0] heard_time_i,
  input  logic [hslt_pkg::RANK_W-1:0] rank_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic                        evicted_o,
  output logic                        stored_o,
  output logic [hslt_pkg::CNT_W-1:0]  entry_count_o,
  output logic [ID_BITS-1:0]          read_id_o,
  output logic [hslt_pkg::PORT_W-1:0] read_port_o,
  output logic [hslt_pkg::TIME_W-1:0] read_time_o,
  output logic                        read_shown_o
);

  hslt_pkg::cmd_t    cmd;
  hslt_pkg::status_t status;

  assign in_ready_o  = cmd.idle;
  assign cfg_ready_o = cmd.idle;

  hslt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  hslt_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ID_BITS      (ID_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_valid_i && cmd.idle),
    .cfg_data_i   (cfg_data_i),
    .op_i         (op_i),
    .station_id_i (station_id_i),
    .port_number_i(port_number_i),
    .is_transmit_i(is_transmit_i),
    .heard_time_i (heard_time_i),
    .rank_i       (rank_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .hit_o        (hit_o),
    .evicted_o    (evicted_o),
    .stored_o     (stored_o),
    .entry_count_o(entry_count_o),
    .read_id_o    (read_id_o),
    .read_port_o  (read_port_o),
    .read_time_o  (read_time_o),
    .read_shown_o (read_shown_o)
  );

endmodule

// ===== hw/rtl/hslt_ram.sv =====
// ----------------------------------------------------------------------------
// hslt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module hslt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hslt_ctrl.sv =====
// ----------------------------------------------------------------------------
// hslt_ctrl
// sequencer for scan, shift, insert and read of the recency table
// ----------------------------------------------------------------------------
module hslt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  hslt_pkg::status_t status_i,
  output hslt_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PLACE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_RD_REQ,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = hslt_pkg::RD_IDX;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status_i.op_read) begin
          state_d = S_RD_REQ;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (status_i.scan_more) begin
          cmd_o.rd_en = 1'b1;
          state_d = S_SCAN_CMP;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_SCAN_CMP: begin
        cmd_o.scan_step = 1'b1;
        state_d = status_i.match ? S_PLACE : S_SCAN_RD;
      end
      S_PLACE: begin
        if (!status_i.found && status_i.cap_zero) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.shift_setup = 1'b1;
          state_d = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (status_i.idx_zero) begin
          state_d = S_INSERT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = hslt_pkg::RD_IDX_M1;
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d = S_FINISH;
      end
      S_RD_REQ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = hslt_pkg::RD_RANK;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/hslt_dp.sv =====
// ----------------------------------------------------------------------------
// hslt_dp
// table storage, counters, compare and result register
// ----------------------------------------------------------------------------
module hslt_dp #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ID_BITS       = 56
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hslt_pkg::cmd_t                cmd_i,
  output hslt_pkg::status_t             status_o,
  input  logic                          cfg_we_i,
  input  logic [hslt_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic                          op_i,
  input  logic [ID_BITS-1:0]            station_id_i,
  input  logic [hslt_pkg::PORT_W-1:0]   port_number_i,
  input  logic                          is_transmit_i,
  input  logic [hslt_pkg::TIME_W-1:0]   heard_time_i,
  input  logic [hslt_pkg::RANK_W-1:0]   rank_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          hit_o,
  output logic                          evicted_o,
  output logic                          stored_o,
  output logic [hslt_pkg::CNT_W-1:0]    entry_count_o,
  output logic [ID_BITS-1:0]            read_id_o,
  output logic [hslt_pkg::PORT_W-1:0]   read_port_o,
  output logic [hslt_pkg::TIME_W-1:0]   read_time_o,
  output logic                          read_shown_o
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int W  = ID_BITS + hslt_pkg::PORT_W + hslt_pkg::TIME_W + 1;
  localparam int CW = hslt_pkg::CNT_W;

  logic                        op_q, tx_q;
  logic [ID_BITS-1:0]          id_q;
  logic [hslt_pkg::PORT_W-1:0] port_q;
  logic [hslt_pkg::TIME_W-1:0] time_q;
  logic [hslt_pkg::RANK_W-1:0] rank_q;

  logic [CW-1:0] cap_q, total_q, total_d, idx_q, idx_d;
  logic          found_q, found_d, dropped_q, dropped_d, kept_q, kept_d;
  logic [CW-1:0] eff_cap, cfg_eff;

  logic          out_valid_q, hit_q, evicted_q, stored_q, shown_q;
  logic [CW-1:0] count_q;
  logic [ID_BITS-1:0]          rid_q;
  logic [hslt_pkg::PORT_W-1:0] rport_q;
  logic [hslt_pkg::TIME_W-1:0] rtime_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0]  wdata, rdata;
  logic          id_eq, port_eq, rank_hit;

  always_comb begin
    eff_cap = cap_q;
    if (32'(cap_q) > TABLE_ENTRIES) begin
      eff_cap = CW'(TABLE_ENTRIES);
    end
    cfg_eff = cfg_data_i;
    if (32'(cfg_data_i) > TABLE_ENTRIES) begin
      cfg_eff = CW'(TABLE_ENTRIES);
    end
  end

  assign id_eq    = rdata[ID_BITS-1:0] == id_q;
  assign port_eq  = rdata[ID_BITS +: hslt_pkg::PORT_W] == port_q;
  assign rank_hit = CW'(rank_q) < total_q;

  always_comb begin
    unique case (cmd_i.rd_sel)
      hslt_pkg::RD_IDX_M1: raddr = AW'(idx_q - CW'(1));
      hslt_pkg::RD_RANK:   raddr = AW'(rank_q);
      default:             raddr = AW'(idx_q);
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(idx_q);
    wdata = rdata;
    if (cmd_i.scan_step && id_eq && !port_eq && !tx_q) begin
      we    = 1'b1;
      wdata = {1'b0, rdata[W-2:0]};
    end else if (cmd_i.shift_wr) begin
      we = 1'b1;
    end else if (cmd_i.insert) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {1'b1, time_q, port_q, id_q};
    end
  end

  hslt_ram #(
    .WIDTH(W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    total_d   = total_q;
    idx_d     = idx_q;
    found_d   = found_q;
    dropped_d = dropped_q;
    kept_d    = kept_q;
    if (cfg_we_i && total_q > cfg_eff) begin
      total_d = cfg_eff;
    end
    if (cmd_i.scan_init) begin
      idx_d     = '0;
      found_d   = 1'b0;
      dropped_d = 1'b0;
      kept_d    = 1'b0;
    end
    if (cmd_i.scan_step) begin
      if (id_eq && port_eq) begin
        found_d = 1'b1;
      end else begin
        idx_d = idx_q + CW'(1);
      end
    end
    if (cmd_i.shift_setup && !found_q) begin
      if (total_q >= eff_cap) begin
        total_d   = eff_cap - CW'(1);
        idx_d     = eff_cap - CW'(1);
        dropped_d = 1'b1;
      end else begin
        idx_d = total_q;
      end
    end
    if (cmd_i.shift_wr) begin
      idx_d = idx_q - CW'(1);
    end
    if (cmd_i.insert) begin
      kept_d = 1'b1;
      if (!found_q) begin
        total_d = total_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CW'(10);
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      total_q <= total_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    found_q   <= found_d;
    dropped_q <= dropped_d;
    kept_q    <= kept_d;
    if (cmd_i.load_item) begin
      op_q   <= op_i;
      id_q   <= station_id_i;
      port_q <= port_number_i;
      tx_q   <= is_transmit_i;
      time_q <= heard_time_i;
      rank_q <= rank_i;
    end
    if (cmd_i.finish) begin
      count_q <= total_q;
      if (op_q) begin
        hit_q     <= rank_hit;
        evicted_q <= 1'b0;
        stored_q  <= 1'b0;
        rid_q     <= rank_hit ? rdata[ID_BITS-1:0] : '0;
        rport_q   <= rank_hit ? rdata[ID_BITS +: hslt_pkg::PORT_W] : '0;
        rtime_q   <= rank_hit ? rdata[ID_BITS+hslt_pkg::PORT_W +: hslt_pkg::TIME_W] : '0;
        shown_q   <= rank_hit & rdata[W-1];
      end else begin
        hit_q     <= found_q;
        evicted_q <= dropped_q;
        stored_q  <= kept_q;
        rid_q     <= '0;
        rport_q   <= '0;
        rtime_q   <= '0;
        shown_q   <= 1'b0;
      end
    end
  end

  assign status_o.op_read   = op_q;
  assign status_o.scan_more = idx_q < total_q;
  assign status_o.match     = id_eq && port_eq;
  assign status_o.found     = found_q;
  assign status_o.idx_zero  = idx_q == '0;
  assign status_o.cap_zero  = eff_cap == '0;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign evicted_o     = evicted_q;
  assign stored_o      = stored_q;
  assign entry_count_o = count_q;
  assign read_id_o     = rid_q;
  assign read_port_o   = rport_q;
  assign read_time_o   = rtime_q;
  assign read_shown_o  = shown_q;

  // table never holds more than the effective capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) total_q <= eff_cap)
    else $error("entry count above capacity");

  // a stored entry means the table is not empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && stored_q |-> count_q != '0)
    else $error("stored with empty table");

  // eviction only happens on an insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && evicted_q |-> stored_q && !hit_q)
    else $error("eviction without insert");

endmodule
